[design/crcfr_pkg.sv]
// ----------------------------------------------------------------------------
// crcfr_pkg: shared types and constants of the CRC16 frame receiver
// Operation codes passed from the parser to the CRC engine, the queue entry
// layout, and the Modbus CRC16 byte step.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  HEADER_RESET = 8'hAA;

	// request queue between parser and CRC engine
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [1:0] OP_START = 2'd0; // header: restart CRC
	localparam logic [1:0] OP_ADD   = 2'd1; // cmd/len: fold into CRC
	localparam logic [1:0] OP_DATA  = 2'd2; // payload: fold and emit
	localparam logic [1:0] OP_END   = 2'd3; // CRC high byte: emit verdict

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [7:0]  index;
		logic [7:0]  cmd;
		logic [7:0]  len;
		logic [15:0] crc_rx;
	} crcfr_req_t;

	// reflected CRC16 step over one byte, one bit per iteration
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else      c = c >> 1;
		end
		return c;
	endfunction

endpackage

[design/crcfr_front.sv]
// ----------------------------------------------------------------------------
// crcfr_front: frame parser
// Tracks the frame phase, holds the header register, and turns each accepted
// byte into at most one request for the CRC engine.
// ----------------------------------------------------------------------------
module crcfr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  header_we,
	input  logic [7:0]            header_wdata,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	output logic                  push,
	output crcfr_pkg::crcfr_req_t req
);
	import crcfr_pkg::*;

	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_CMD  = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRCL = 3'd4;
	localparam logic [2:0] PH_CRCH = 3'd5;

	logic [2:0] phase_q, phase_d;
	logic [7:0] header_q;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d;
	logic [7:0] count_q, count_d;
	logic [7:0] crcl_q, crcl_d;
	logic [8:0] count_inc;

	assign count_inc = {1'b0, count_q} + 9'd1;

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		count_d = count_q;
		crcl_d  = crcl_q;
		push    = 1'b0;
		req     = '{op: OP_ADD, data: rx_byte, index: 8'd0, cmd: cmd_q, len: len_q,
		            crc_rx: 16'd0};
		if (accept) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (rx_byte == header_q) begin
						push    = 1'b1;
						req.op  = OP_START;
						count_d = 8'd0;
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					push    = 1'b1;
					cmd_d   = rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					push    = 1'b1;
					len_d   = rx_byte;
					count_d = 8'd0;
					phase_d = (rx_byte == 8'd0) ? PH_CRCL : PH_DATA;
				end
				PH_DATA: begin
					push      = 1'b1;
					req.op    = OP_DATA;
					req.index = count_q;
					count_d   = count_inc[7:0];
					if (count_inc >= {1'b0, len_q}) phase_d = PH_CRCL;
				end
				PH_CRCL: begin
					crcl_d  = rx_byte;
					phase_d = PH_CRCH;
				end
				PH_CRCH: begin
					push       = 1'b1;
					req.op     = OP_END;
					req.data   = 8'd0;
					req.crc_rx = {rx_byte, crcl_q};
					count_d    = 8'd0;
					phase_d    = PH_WAIT;
				end
				default: begin
					count_d = 8'd0;
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			header_q <= HEADER_RESET;
			cmd_q    <= 8'd0;
			len_q    <= 8'd0;
			count_q  <= 8'd0;
			crcl_q   <= 8'd0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			count_q <= count_d;
			crcl_q  <= crcl_d;
			if (header_we) header_q <= header_wdata;
		end
	end

endmodule

[design/crcfr_queue.sv]
// ----------------------------------------------------------------------------
// crcfr_queue: request queue
// Small first-in first-out buffer of parser requests in flip-flops.
// ----------------------------------------------------------------------------
module crcfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  crcfr_pkg::crcfr_req_t push_req,
	input  logic                  pop,
	output logic                  not_empty,
	output logic                  full,
	output crcfr_pkg::crcfr_req_t head
);
	import crcfr_pkg::*;

	crcfr_req_t      slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			priority if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push)     count_q <= count_q - 1'b1;
		end
	end

endmodule

[design/crcfr_back.sv]
// ----------------------------------------------------------------------------
// crcfr_back: CRC engine and result register
// Runs the CRC16 over queued requests and presents payload and frame-end
// results from an output register.
// ----------------------------------------------------------------------------
module crcfr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  crcfr_pkg::crcfr_req_t req,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic [7:0]            payload_byte,
	output logic [7:0]            payload_index,
	output logic [7:0]            frame_cmd,
	output logic [7:0]            payload_len,
	output logic [15:0]           crc_received,
	output logic [15:0]           crc_computed,
	output logic                  crc_ok
);
	import crcfr_pkg::*;

	logic [15:0] crc_q, crc_next;
	logic        emits, slot_free;

	assign emits     = (req.op == OP_DATA) || (req.op == OP_END);
	assign slot_free = !out_valid || out_ready;
	// CRC-only requests never wait on the output side
	assign pop       = req_valid && (!emits || slot_free);
	assign crc_next  = crc_step((req.op == OP_START) ? CRC_INIT : crc_q, req.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			out_valid <= 1'b0;
		end else begin
			out_valid <= (pop && emits) || (out_valid && !out_ready);
			if (pop && (req.op != OP_END)) crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			frame_cmd    <= req.cmd;
			payload_len  <= req.len;
			if (req.op == OP_END) begin
				result_kind   <= KIND_END;
				payload_byte  <= 8'd0;
				payload_index <= 8'd0;
				crc_received  <= req.crc_rx;
				crc_computed  <= crc_q;
				crc_ok        <= (req.crc_rx == crc_q);
			end else begin
				result_kind   <= KIND_PAYLOAD;
				payload_byte  <= req.data;
				payload_index <= req.index;
				crc_received  <= 16'd0;
				crc_computed  <= crc_next;
				crc_ok        <= 1'b0;
			end
		end
	end

endmodule

[design/crc16_frame_receiver.sv]
// Path: requests are queued, and results are loaded into the output register.
// Throughput: one byte per cycle, and the CRC engine folds one, unless stalled.
// Backpressure: in_ready drops only when the four-entry request queue is full.
// Reset: arst_n clears phase, header register (to 0xAA), CRC and queue at once.
// ----------------------------------------------------------------------------
// crc16_frame_receiver: framed UART receiver with Modbus CRC16 check
// Parses header/cmd/len/payload/CRC frames, streams payload bytes with their
// index and reports a frame-end verdict on the received CRC.
// ----------------------------------------------------------------------------
module crc16_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// header register write
	input  logic        header_we,
	input  logic [7:0]  header_wdata,
	// byte input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [7:0]  frame_cmd,
	output logic [7:0]  payload_len,
	output logic [15:0] crc_received,
	output logic [15:0] crc_computed,
	output logic        crc_ok
);
	import crcfr_pkg::*;

	logic       accept;
	logic       push, pop, q_not_empty, q_full;
	crcfr_req_t push_req, head_req;

	// Every byte is taken while the queue has room, even bytes that make no
	// request (ignored bytes, CRC low byte); order is preserved by the queue.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// front: phase tracking and classification of each byte
	crcfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.header_we    (header_we),
		.header_wdata (header_wdata),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.push         (push),
		.req          (push_req)
	);

	// decouples the parser from output backpressure
	crcfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.pop       (pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head      (head_req)
	);

	// back: CRC fold and result register
	crcfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (q_not_empty),
		.req           (head_req),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_cmd     (frame_cmd),
		.payload_len   (payload_len),
		.crc_received  (crc_received),
		.crc_computed  (crc_computed),
		.crc_ok        (crc_ok)
	);

endmodule

[sim/crc16_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_receiver_tb: self-checking bench for the CRC16 frame receiver
// Feeds framed and noisy byte streams under random backpressure, predicts
// every payload and frame-end result in the bench and checks them in order.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_tb;
	import crcfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000; // cycles with no request moving
	localparam int DRAIN_CYCLES   = 8;    // > output register plus four-entry queue
	localparam int LONG_HOLD      = 200;  // receiver hold-off, in cycles

	// parser phases of the bench's own copy of the receiver
	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_CMD  = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRCL = 3'd4;
	localparam logic [2:0] PH_CRCH = 3'd5;

	// one result as seen on the output channel
	typedef struct packed {
		logic        kind;
		logic [7:0]  pbyte;
		logic [7:0]  pidx;
		logic [7:0]  cmd;
		logic [7:0]  len;
		logic [15:0] crc_rx;
		logic [15:0] crc_calc;
		logic        ok;
	} rx_result_t;

	// DUT ports; every input starts at a known value
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        header_we    = 1'b0;
	logic [7:0]  header_wdata = 8'h00;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte      = 8'h00;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [7:0]  frame_cmd;
	logic [7:0]  payload_len;
	logic [15:0] crc_received;
	logic [15:0] crc_computed;
	logic        crc_ok;

	// byte requests waiting for the driver, results waiting for the DUT
	logic [7:0]  pending_bytes[$];
	rx_result_t  expected_results[$];

	// receiver model state
	logic [7:0]  hdr_model   = HEADER_RESET;
	logic [2:0]  phase_m     = PH_WAIT;
	logic [15:0] crc_m       = CRC_INIT;
	logic [7:0]  cmd_m       = 8'h00;
	logic [7:0]  len_m       = 8'h00;
	logic [7:0]  count_m     = 8'h00;
	logic [7:0]  crcl_m      = 8'h00;

	// traffic shaping, set by the sequence
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req      = 1'b0; // toggled to ask for one long receiver hold-off
	bit hold_seen     = 1'b0;
	int hold_left     = 0;

	int err_count     = 0;
	int quiet_cycles  = 0;

	crc16_frame_receiver i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.header_we     (header_we),
		.header_wdata  (header_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_cmd     (frame_cmd),
		.payload_len   (payload_len),
		.crc_received  (crc_received),
		.crc_computed  (crc_computed),
		.crc_ok        (crc_ok)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Modbus CRC16, bit-serial: feed data lsb first into the reflected register
	function automatic logic [15:0] modbus_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r  = r >> 1;
			if (fb) r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	task automatic report_error(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// advance the receiver model by one accepted byte
	task automatic predict_byte(input logic [7:0] b);
		rx_result_t r;
		r = '0;
		unique case (phase_m)
		PH_WAIT: begin
			// anything but the header is dropped while hunting
			if (b == hdr_model) begin
				crc_m   = modbus_fold(CRC_INIT, b);
				count_m = 8'h00;
				phase_m = PH_CMD;
			end
		end
		PH_CMD: begin
			cmd_m   = b;
			crc_m   = modbus_fold(crc_m, b);
			phase_m = PH_LEN;
		end
		PH_LEN: begin
			len_m   = b;
			crc_m   = modbus_fold(crc_m, b);
			count_m = 8'h00;
			// empty payload skips straight to the CRC bytes
			phase_m = (b == 8'h00) ? PH_CRCL : PH_DATA;
		end
		PH_DATA: begin
			crc_m      = modbus_fold(crc_m, b);
			r.kind     = KIND_PAYLOAD;
			r.pbyte    = b;
			r.pidx     = count_m;
			r.cmd      = cmd_m;
			r.len      = len_m;
			r.crc_calc = crc_m; // running CRC including this byte
			expected_results.push_back(r);
			count_m = count_m + 8'd1;
			if (count_m >= len_m) phase_m = PH_CRCL;
		end
		PH_CRCL: begin
			crcl_m  = b;
			phase_m = PH_CRCH;
		end
		PH_CRCH: begin
			r.kind     = KIND_END;
			r.cmd      = cmd_m;
			r.len      = len_m;
			r.crc_rx   = {b, crcl_m};
			r.crc_calc = crc_m;
			r.ok       = ({b, crcl_m} == crc_m);
			expected_results.push_back(r);
			phase_m = PH_WAIT;
			count_m = 8'h00;
		end
		default: begin
			phase_m = PH_WAIT;
			count_m = 8'h00;
		end
		endcase
	endtask

	// driver: one request per free slot, payload held until accepted
	always @(posedge clk) begin
		if (in_valid && in_ready) predict_byte(rx_byte);
		if (!in_valid || in_ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte  <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check the result request, then pick the next ready level
	always @(posedge clk) begin
		rx_result_t got;
		rx_result_t want;
		if (out_valid && out_ready) begin
			got = '{result_kind, payload_byte, payload_index, frame_cmd, payload_len,
				crc_received, crc_computed, crc_ok};
			if (expected_results.size() == 0) begin
				report_error($sformatf("result with nothing expected: %h", got));
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind)
					report_error($sformatf("result_kind %0h want %0h", got.kind, want.kind));
				if (got.pbyte !== want.pbyte)
					report_error($sformatf("payload_byte %0h want %0h", got.pbyte, want.pbyte));
				if (got.pidx !== want.pidx)
					report_error($sformatf("payload_index %0d want %0d", got.pidx, want.pidx));
				if (got.cmd !== want.cmd)
					report_error($sformatf("frame_cmd %0h want %0h", got.cmd, want.cmd));
				if (got.len !== want.len)
					report_error($sformatf("payload_len %0d want %0d", got.len, want.len));
				if (got.crc_rx !== want.crc_rx)
					report_error($sformatf("crc_received %0h want %0h", got.crc_rx, want.crc_rx));
				if (got.crc_calc !== want.crc_calc)
					report_error($sformatf("crc_computed %0h want %0h",
						got.crc_calc, want.crc_calc));
				if (got.ok !== want.ok)
					report_error($sformatf("crc_ok %0b want %0b", got.ok, want.ok));
			end
		end
		// a long hold-off lets the request queue fill and stall the input
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: nothing moving on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// idle = sender drained and every predicted result seen; polled on the
	// falling edge so the driver's and monitor's updates have all settled
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
		// bytes that give no result may still sit in the DUT
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_header(input logic [7:0] v);
		@(posedge clk);
		header_we    <= 1'b1;
		header_wdata <= v;
		hdr_model     = v;
		@(posedge clk);
		header_we    <= 1'b0;
	endtask

	// full frame with the current header; fill < 0 means random payload
	task automatic push_frame(input logic [7:0] cmd, input int len, input bit corrupt,
			input int fill);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = modbus_fold(CRC_INIT, hdr_model);
		crc = modbus_fold(crc, cmd);
		crc = modbus_fold(crc, len[7:0]);
		pending_bytes.push_back(hdr_model);
		pending_bytes.push_back(cmd);
		pending_bytes.push_back(len[7:0]);
		for (int i = 0; i < len; i++) begin
			if (fill >= 0) b = fill[7:0];
			else if ($urandom_range(9) == 0) b = hdr_model; // header as data
			else b = 8'($urandom_range(255));
			crc = modbus_fold(crc, b);
			pending_bytes.push_back(b);
		end
		if (corrupt) crc = crc ^ 16'($urandom_range(65535, 1));
		pending_bytes.push_back(crc[7:0]);
		pending_bytes.push_back(crc[15:8]);
	endtask

	// mostly good frames, some with bad CRC, plus noise and cut-off frames
	task automatic push_random_traffic(input int target);
		int start;
		int pick;
		int len;
		int cut;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8);
				push_frame(8'($urandom_range(255)), len, $urandom_range(4) == 0, -1);
			end else if (pick < 85) begin
				pending_bytes.push_back(8'($urandom_range(255)));
			end else begin
				// frame that stops short; what follows lands inside it
				len = $urandom_range(8, 1);
				cut = $urandom_range(len - 1);
				pending_bytes.push_back(hdr_model);
				pending_bytes.push_back(8'($urandom_range(255)));
				pending_bytes.push_back(len[7:0]);
				for (int i = 0; i < cut; i++)
					pending_bytes.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at the reset header, sender 33 / receiver 75 idle
		send_idle_pct = 33;
		recv_idle_pct = 75;
		pending_bytes.push_back(8'h00); // dropped while hunting
		pending_bytes.push_back(8'h55);
		push_frame(8'h00, 0, 1'b0, -1);    // empty payload
		push_frame(8'hFF, 1, 1'b1, 255);   // bad CRC still reports
		push_frame(HEADER_RESET, 2, 1'b0, int'(HEADER_RESET)); // header as frame data
		wait_drained();

		write_header(8'h00);
		push_random_traffic(200);
		wait_drained();

		// roles swapped: sender 75 / receiver 33, then a long hold-off
		send_idle_pct = 75;
		recv_idle_pct = 33;
		write_header(8'hFF);
		push_random_traffic(100);
		wait_drained();
		send_idle_pct = 0;
		push_random_traffic(100);
		hold_req = ~hold_req;
		wait_drained();

		// no idling, random header, one maximum-length frame
		send_idle_pct = 33;
		recv_idle_pct = 0;
		send_idle_pct = 0;
		write_header(8'($urandom_range(255)));
		push_frame(8'($urandom_range(255)), 255, 1'b0, -1);
		push_random_traffic(170);
		wait_drained();

		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
design/crcfr_pkg.sv
design/crcfr_front.sv
design/crcfr_queue.sv
design/crcfr_back.sv
design/crc16_frame_receiver.sv
sim/crc16_frame_receiver_tb.sv
